// ----- src/sfr_pkg.sv -----
// Package for the stuffed frame receiver: byte codes, result kinds, widths and
// the result record shared by the parser and the top level.
// No dependencies.
package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int LEN_W       = 11;
    localparam int MAX_PAYLOAD = 1024;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_MASK  = 8'h20;
    localparam logic [BYTE_W-1:0] CTRL_I0   = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_I1   = 8'h80;
    localparam logic [BYTE_W-1:0] DISC_CTRL = 8'h0B;
    localparam logic [BYTE_W-1:0] RR_BASE   = 8'hAA;
    localparam logic [BYTE_W-1:0] REJ_BASE  = 8'h54;
    localparam logic [BYTE_W-1:0] ADDR_RST  = 8'h03;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DISC    = 2'd3;

    // register index, taken from the word address bit of paddr
    localparam logic REG_EXP_ADDR = 1'b0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] reply_control;
        logic [LEN_W-1:0]  payload_length;
        logic              frame_sequence;
    } t_result;

endpackage

// ----- src/sfr_rx_if.sv -----
// Receive byte channel: valid/ready handshake carrying one raw line byte.
// Depends on sfr_pkg.
interface sfr_rx_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/sfr_res_if.sv -----
// Result channel: valid/ready handshake carrying one deframer result.
// Depends on sfr_pkg.
interface sfr_res_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] reply_control;
    logic [LEN_W-1:0]  payload_length;
    logic              frame_sequence;

    modport source (output valid, output kind, output data_byte, output reply_control,
                    output payload_length, output frame_sequence, input ready);
    modport sink (input valid, input kind, input data_byte, input reply_control,
                  input payload_length, input frame_sequence, output ready);
endinterface

// ----- src/sfr_parser.sv -----
// Frame parser: header check, destuffing, delayed payload, data check and
// frame verdict, one byte per fire. Depends on sfr_pkg.
module sfr_parser import sfr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_exp_addr,
    output logic              o_emit,
    output t_result           o_result
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_FLAG = 3'd1;
    localparam logic [2:0] PH_ADDR = 3'd2;
    localparam logic [2:0] PH_CTRL = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_ESC  = 3'd5;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

    logic [2:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_held_control, n_held_control;
    logic [BYTE_W-1:0] r_held_byte, n_held_byte;
    logic              r_held_valid, n_held_valid;
    logic [BYTE_W-1:0] r_running_xor, n_running_xor;
    logic [LEN_W-1:0]  r_byte_count, n_byte_count;
    logic              r_overflowed, n_overflowed;
    logic              r_reply_seq, n_reply_seq;

    logic              take;
    logic [BYTE_W-1:0] take_byte;
    logic              good;

    assign good = r_held_valid && !r_overflowed && (r_held_byte == r_running_xor);

    always_comb begin
        n_phase        = r_phase;
        n_held_control = r_held_control;
        n_held_byte    = r_held_byte;
        n_held_valid   = r_held_valid;
        n_running_xor  = r_running_xor;
        n_byte_count   = r_byte_count;
        n_overflowed   = r_overflowed;
        n_reply_seq    = r_reply_seq;
        take           = 1'b0;
        take_byte      = i_byte;
        o_emit         = 1'b0;
        o_result       = '0;

        if (i_fire) begin
            case (r_phase)
                PH_FLAG: begin
                    if (i_byte == i_exp_addr) begin
                        n_phase = PH_ADDR;
                    end else if (i_byte != FLAG_BYTE) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_ADDR: begin
                    if (i_byte == CTRL_I0 || i_byte == CTRL_I1) begin
                        n_held_control = i_byte;
                        n_phase        = PH_CTRL;
                    end else if (i_byte == FLAG_BYTE) begin
                        n_phase = PH_FLAG;
                    end else if (i_byte == DISC_CTRL) begin
                        n_phase                = PH_HUNT;
                        o_emit                 = 1'b1;
                        o_result.kind          = KIND_DISC;
                        o_result.reply_control = DISC_CTRL;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_CTRL: begin
                    if (i_byte == (i_exp_addr ^ r_held_control)) begin
                        n_phase       = PH_DATA;
                        n_held_byte   = '0;
                        n_held_valid  = 1'b0;
                        n_running_xor = '0;
                        n_byte_count  = '0;
                        n_overflowed  = 1'b0;
                    end else if (i_byte == FLAG_BYTE) begin
                        n_phase = PH_FLAG;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (i_byte == ESC_BYTE) begin
                        n_phase = PH_ESC;
                    end else if (i_byte == FLAG_BYTE) begin
                        // closing flag: held byte is the data check
                        n_phase                 = PH_HUNT;
                        o_emit                  = 1'b1;
                        o_result.payload_length = r_byte_count;
                        o_result.frame_sequence = r_held_control[7];
                        if (good) begin
                            o_result.kind          = KIND_GOOD;
                            o_result.reply_control = RR_BASE | {7'd0, r_reply_seq};
                            n_reply_seq            = !r_reply_seq;
                        end else begin
                            o_result.kind          = KIND_BAD;
                            o_result.reply_control = REJ_BASE | {7'd0, r_reply_seq};
                        end
                    end else begin
                        take = 1'b1;
                    end
                end
                PH_ESC: begin
                    n_phase   = PH_DATA;
                    take      = 1'b1;
                    take_byte = i_byte ^ ESC_MASK;
                end
                default: begin
                    n_phase = (i_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                end
            endcase

            // release the held byte as payload if under the limit, then hold the new one
            if (take) begin
                if (r_held_valid) begin
                    if (r_byte_count < LEN_MAX) begin
                        n_running_xor           = r_running_xor ^ r_held_byte;
                        n_byte_count            = r_byte_count + LEN_W'(1);
                        o_emit                  = 1'b1;
                        o_result.kind           = KIND_PAYLOAD;
                        o_result.data_byte      = r_held_byte;
                        o_result.frame_sequence = r_held_control[7];
                    end else begin
                        n_overflowed = 1'b1;
                    end
                end
                n_held_byte  = take_byte;
                n_held_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_held_control <= '0;
            r_held_byte    <= '0;
            r_held_valid   <= 1'b0;
            r_running_xor  <= '0;
            r_byte_count   <= '0;
            r_overflowed   <= 1'b0;
            r_reply_seq    <= 1'b1;
        end else begin
            r_phase        <= n_phase;
            r_held_control <= n_held_control;
            r_held_byte    <= n_held_byte;
            r_held_valid   <= n_held_valid;
            r_running_xor  <= n_running_xor;
            r_byte_count   <= n_byte_count;
            r_overflowed   <= n_overflowed;
            r_reply_seq    <= n_reply_seq;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= LEN_MAX)
        else $error("payload count above limit");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflowed |-> (r_byte_count == LEN_MAX))
        else $error("overflow flagged before payload limit");

    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.kind == KIND_PAYLOAD) |-> (r_phase == PH_DATA || r_phase == PH_ESC))
        else $error("payload byte emitted outside data phase");

    a_good_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.kind == KIND_GOOD) |=> (r_reply_seq != $past(r_reply_seq)))
        else $error("reply bit not toggled after good frame");

endmodule

// ----- src/stuffed_frame_receiver_core.sv -----
// A transferred byte is held in the byte register, goes to the parser when it advances,
// and any result it produces is loaded into the result register and offered to the sink.
// Throughput: one byte per cycle; the byte register stalls only when the result
// register is full and the sink does not take it in the same cycle.
// Reset (i_rst_n low, synchronous): both stages empty, parser hunting for a flag,
// reply bit 1, expected address 0x03.
// Depends on sfr_pkg, sfr_rx_if, sfr_res_if, sfr_parser.
module stuffed_frame_receiver_core import sfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sfr_rx_if.sink             i_rx,
    sfr_res_if.source          o_res,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output logic [PDATA_W-1:0] o_prdata,
    output logic               o_pready
);

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic [BYTE_W-1:0] r_exp_addr;

    logic    out_free;
    logic    s1_adv;
    logic    cfg_wr;
    logic    emit;
    t_result result;

    assign out_free   = !r_out_valid || o_res.ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign i_rx.ready = !r_s1_valid || out_free;

    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready
                      && (i_paddr[2] == REG_EXP_ADDR);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_EXP_ADDR) ?
                      {{(PDATA_W-BYTE_W){1'b0}}, r_exp_addr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr <= ADDR_RST;
        end else if (cfg_wr) begin
            r_exp_addr <= i_pwdata[BYTE_W-1:0];
        end
    end

    // byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_s1_byte <= i_rx.rx_byte;
        end
    end

    sfr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_adv),
        .i_byte     (r_s1_byte),
        .i_exp_addr (r_exp_addr),
        .o_emit     (emit),
        .o_result   (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            r_out <= result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out.kind;
    assign o_res.data_byte      = r_out.data_byte;
    assign o_res.reply_control  = r_out.reply_control;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.frame_sequence = r_out.frame_sequence;

endmodule
